FILE: rtl/core/sdes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S-DES package
// Types, permutation tables, S-boxes and the round/key functions shared by
// the key schedule and the cipher datapath.
// ----------------------------------------------------------------------------
package sdes_pkg;

   localparam int KEY_W   = 10;
   localparam int BYTE_W  = 8;
   localparam int HALF_W  = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_CIPHER_KEY    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNTER_START = 1'b1;

   localparam logic [KEY_W-1:0]  KEY_RESET   = 10'd509;
   localparam logic [BYTE_W-1:0] START_RESET = 8'd0;

   // Tables number bits from 1 at the MSB.
   localparam int P10_TAB   [10] = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
   localparam int P8_TAB    [8]  = '{6, 3, 7, 4, 8, 5, 10, 9};
   localparam int IP_TAB    [8]  = '{2, 6, 3, 1, 4, 8, 5, 7};
   localparam int IPINV_TAB [8]  = '{4, 1, 3, 5, 7, 2, 8, 6};
   localparam int EP_TAB    [8]  = '{4, 1, 2, 3, 2, 3, 4, 1};
   localparam int P4_TAB    [4]  = '{2, 4, 3, 1};

   localparam logic [1:0] SBOX0 [4][4] = '{
      '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd3, 2'd2, 2'd1, 2'd0},
      '{2'd0, 2'd2, 2'd1, 2'd3},
      '{2'd3, 2'd1, 2'd3, 2'd2}};
   localparam logic [1:0] SBOX1 [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd2, 2'd0, 2'd1, 2'd3},
      '{2'd3, 2'd0, 2'd1, 2'd0},
      '{2'd2, 2'd1, 2'd0, 2'd3}};

   typedef struct packed {
      logic [BYTE_W-1:0] k1;
      logic [BYTE_W-1:0] k2;
   } subkey_type;

   function automatic logic [9:0] perm_p10(input logic [9:0] v);
      logic [9:0] o;
      o = '0;
      for (int i = 0; i < 10; i++) o[9-i] = v[10-P10_TAB[i]];
      return o;
   endfunction

   function automatic logic [7:0] perm_p8(input logic [9:0] v);
      logic [7:0] o;
      o = '0;
      for (int i = 0; i < 8; i++) o[7-i] = v[10-P8_TAB[i]];
      return o;
   endfunction

   function automatic logic [7:0] perm_ip(input logic [7:0] v);
      logic [7:0] o;
      o = '0;
      for (int i = 0; i < 8; i++) o[7-i] = v[8-IP_TAB[i]];
      return o;
   endfunction

   function automatic logic [7:0] perm_ipinv(input logic [7:0] v);
      logic [7:0] o;
      o = '0;
      for (int i = 0; i < 8; i++) o[7-i] = v[8-IPINV_TAB[i]];
      return o;
   endfunction

   function automatic logic [7:0] perm_ep(input logic [3:0] v);
      logic [7:0] o;
      o = '0;
      for (int i = 0; i < 8; i++) o[7-i] = v[4-EP_TAB[i]];
      return o;
   endfunction

   function automatic logic [3:0] perm_p4(input logic [3:0] v);
      logic [3:0] o;
      o = '0;
      for (int i = 0; i < 4; i++) o[3-i] = v[4-P4_TAB[i]];
      return o;
   endfunction

   function automatic logic [4:0] rotl5_1(input logic [4:0] x);
      return {x[3:0], x[4]};
   endfunction

   function automatic logic [4:0] rotl5_2(input logic [4:0] x);
      return {x[2:0], x[4:3]};
   endfunction

   // Feistel function: expand, mix subkey, two S-boxes, P4.
   function automatic logic [3:0] round_f(input logic [3:0] half,
                                          input logic [7:0] sub);
      logic [7:0] e;
      logic [3:0] a;
      logic [3:0] b;
      logic [1:0] s0;
      logic [1:0] s1;
      e  = perm_ep(half) ^ sub;
      a  = e[7:4];
      b  = e[3:0];
      s0 = SBOX0[{a[3], a[0]}][a[2:1]];
      s1 = SBOX1[{b[3], b[0]}][b[2:1]];
      return perm_p4({s0, s1});
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sdes_counter_mode_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S-DES counter mode cipher
// Byte stream encrypt/decrypt with an S-DES keystream over an 8-bit counter.
// ----------------------------------------------------------------------------
// One request per cycle; each result appears in the cycle after its request
// is accepted, held in a single output register. A new request is taken while
// that register is empty or in the same cycle its result is taken; while a
// result waits unaccepted, requests stall. The keystream byte is S-DES of
// (counter_start + offset) mod 256; the offset clears at reset or on a
// request with restart set and advances by one per request. Write the key
// (index 0) and counter start (index 1) only while the block is idle; the
// offset survives register writes.
module sdes_counter_mode_cipher
   import sdes_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [BYTE_W-1:0]     req_data_byte,
   input  wire logic                  req_restart,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [BYTE_W-1:0]          rsp_result_byte,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   subkey_type        subkeys;
   logic [BYTE_W-1:0] counter_start;
   logic [BYTE_W-1:0] offset_ff;
   logic [BYTE_W-1:0] offset_in;
   logic [BYTE_W-1:0] offset_cur;
   logic [BYTE_W-1:0] block;
   logic [BYTE_W-1:0] keystream;
   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] result_ff;
   logic [BYTE_W-1:0] result_in;
   logic              accept;

   sdes_key_sched u_key_sched (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .subkeys       (subkeys),
      .counter_start (counter_start)
   );

   sdes_encrypt u_encrypt (
      .block     (block),
      .subkeys   (subkeys),
      .keystream (keystream)
   );

   assign req_ready = !valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      offset_cur = req_restart ? '0 : offset_ff;
      block      = counter_start + offset_cur;
      offset_in  = offset_ff;
      valid_in   = valid_ff;
      result_in  = result_ff;
      if (accept) begin
         offset_in = offset_cur + 1'b1;
         valid_in  = 1'b1;
         result_in = req_data_byte ^ keystream;
      end else if (rsp_ready) begin
         valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         offset_ff <= offset_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_byte = result_ff;

endmodule
`default_nettype wire

FILE: rtl/core/sdes_key_sched.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S-DES key schedule and control registers
// Holds the key and counter start, derives both round subkeys from the key.
// ----------------------------------------------------------------------------
module sdes_key_sched
   import sdes_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output subkey_type                 subkeys,
   output logic [BYTE_W-1:0]          counter_start
);

   logic [KEY_W-1:0]  key_ff;
   logic [KEY_W-1:0]  key_in;
   logic [BYTE_W-1:0] start_ff;
   logic [BYTE_W-1:0] start_in;
   logic [9:0]        p10_v;
   logic [4:0]        hi1;
   logic [4:0]        lo1;
   logic [4:0]        hi2;
   logic [4:0]        lo2;

   always_comb begin
      key_in   = key_ff;
      start_in = start_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_CIPHER_KEY:    key_in   = csr_wdata[KEY_W-1:0];
            CSR_COUNTER_START: start_in = csr_wdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= KEY_RESET;
         start_ff <= START_RESET;
      end else begin
         key_ff   <= key_in;
         start_ff <= start_in;
      end
   end

   // Shift by 1 for K1, then by 2 more for K2.
   always_comb begin
      p10_v      = perm_p10(key_ff);
      hi1        = rotl5_1(p10_v[9:5]);
      lo1        = rotl5_1(p10_v[4:0]);
      hi2        = rotl5_2(hi1);
      lo2        = rotl5_2(lo1);
      subkeys.k1 = perm_p8({hi1, lo1});
      subkeys.k2 = perm_p8({hi2, lo2});
   end

   assign counter_start = start_ff;

endmodule
`default_nettype wire

FILE: rtl/core/sdes_encrypt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S-DES block encryption
// Two Feistel rounds on one 8-bit block; pure permutation and S-box logic.
// ----------------------------------------------------------------------------
module sdes_encrypt
   import sdes_pkg::*;
(
   input  wire logic [BYTE_W-1:0] block,
   input  wire subkey_type        subkeys,
   output logic [BYTE_W-1:0]      keystream
);

   logic [BYTE_W-1:0] ip_v;
   logic [HALF_W-1:0] mid;
   logic [HALF_W-1:0] left2;

   always_comb begin
      ip_v      = perm_ip(block);
      mid       = ip_v[7:4] ^ round_f(ip_v[3:0], subkeys.k1);
      // halves swap between the rounds
      left2     = ip_v[3:0] ^ round_f(mid, subkeys.k2);
      keystream = perm_ipinv({left2, mid});
   end

endmodule
`default_nettype wire
